// File: rtl/sgm_pkg.sv
// shared types and constants for the sobel gradient magnitude core
`timescale 1ns / 1ps

package sgm_pkg;

   // sample format
   localparam int SAMPLE_BITS = 12;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

   // configuration register widths and limits
   localparam int WIDTH_REG_BITS  = 9;
   localparam int HEIGHT_REG_BITS = 12;
   localparam int CSR_DATA_BITS   = 12;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int MIN_DIM         = 3;

   // result field widths
   localparam int OUT_COL_BITS = 8;
   localparam int ROW_BITS     = 12;

   // datapath widths
   localparam int SUM_BITS  = SAMPLE_BITS + 4;  // signed kernel sum
   localparam int ABS_BITS  = SAMPLE_BITS + 2;  // |gx|, |gy| <= 4 * max sample
   localparam int SQ_BITS   = 2 * ABS_BITS;
   localparam int RAD_BITS  = SQ_BITS + 2;      // sum of squares, kept even
   localparam int ROOT_BITS = RAD_BITS / 2;
   localparam int LINE_BITS = 2 * SAMPLE_BITS;  // {older row, previous row}

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SQUARE,
      ST_START,
      ST_ROOT,
      ST_HOLD
   } state_type;

endpackage

// File: rtl/sgm_line_mem.sv
// line memory holding the two previous image rows, one word per column
`timescale 1ns / 1ps

module sgm_line_mem #(
   parameter int DEPTH     = 256,
   parameter int ADDR_BITS = 8
) (
   input  logic                             clock,
   input  logic                             rd_en,
   input  logic [ADDR_BITS-1:0]             rd_addr,
   output logic [sgm_pkg::LINE_BITS-1:0]    rd_data,
   input  logic                             wr_en,
   input  logic [ADDR_BITS-1:0]             wr_addr,
   input  logic [sgm_pkg::LINE_BITS-1:0]    wr_data
);

   logic [sgm_pkg::LINE_BITS-1:0] mem_ff [DEPTH];
   logic [sgm_pkg::LINE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sgm_root.sv
// bit-serial integer square root, one result bit per cycle
`timescale 1ns / 1ps

module sgm_root (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [sgm_pkg::RAD_BITS-1:0]     radicand,
   output logic                             done,
   output logic [sgm_pkg::ROOT_BITS-1:0]    root
);

   localparam int REM_BITS = sgm_pkg::ROOT_BITS + 2;
   localparam int TRY_BITS = REM_BITS + 2;
   localparam int CNT_BITS = $clog2(sgm_pkg::ROOT_BITS + 1);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [CNT_BITS-1:0]            cnt_ff, cnt_in;
   logic [sgm_pkg::RAD_BITS-1:0]   rad_ff, rad_in;
   logic [REM_BITS-1:0]            rem_ff, rem_in;
   logic [sgm_pkg::ROOT_BITS-1:0]  root_ff, root_in;
   logic [TRY_BITS-1:0]            shifted;
   logic [TRY_BITS-1:0]            trial;
   logic [TRY_BITS-1:0]            diff;
   logic                           fits;

   // bring down the next two radicand bits and try root*4+1
   assign shifted = {rem_ff, rad_ff[sgm_pkg::RAD_BITS-1 -: 2]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign diff    = shifted - trial;
   assign fits    = shifted >= trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(sgm_pkg::ROOT_BITS - 1);
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[sgm_pkg::RAD_BITS-3:0], 2'b00};
         rem_in  = fits ? diff[REM_BITS-1:0] : shifted[REM_BITS-1:0];
         root_in = {root_ff[sgm_pkg::ROOT_BITS-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: rtl/sobel_gradient_magnitude_core.sv
// top level of the streaming 3x3 sobel gradient magnitude core
`timescale 1ns / 1ps

// Streaming 3x3 Sobel edge strength. Pixels arrive in raster order, one 12-bit
// unsigned sample per transaction; for every pixel whose 3x3 window is complete
// (column and row counters both at least 2) the core emits one transaction with
// floor(sqrt(gx^2 + gy^2)) / 2 saturated at 4095, tagged with the column and row
// of the window center. Border pixels produce no result. Both previous rows live
// in one line memory of MAX_WIDTH words, each word holding the two older samples
// of a column; it is read in the cycle a pixel is accepted and written back in
// the following cycle, so accesses never overlap. An interior pixel goes through
// the memory read, the kernel stage, the squaring stage, the root load and the
// bit-serial square root (one result bit per cycle over 15 bits). The input side
// is free again as soon as the result sits in the output register, even while it
// waits on rsp_stall. The user must write image width and height through the csr
// port only while the core is idle; the core does not enforce this. Counters are
// not cleared on a write and wrap at the next advance if they lie beyond the new
// size. The line memory needs no clearing after reset.
module sobel_gradient_magnitude_core #(
   parameter int MAX_WIDTH = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // pixel input
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [sgm_pkg::SAMPLE_BITS-1:0]       req_pixel_value,
   // gradient output
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sgm_pkg::SAMPLE_BITS-1:0]       rsp_gradient,
   output logic [sgm_pkg::OUT_COL_BITS-1:0]      rsp_out_col,
   output logic [sgm_pkg::ROW_BITS-1:0]          rsp_out_row,
   // configuration
   input  logic                                  csr_write_en,
   input  logic [sgm_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sgm_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int COL_BITS  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int CMP_BITS  = ($clog2(MAX_WIDTH + 1) > sgm_pkg::WIDTH_REG_BITS) ?
                              $clog2(MAX_WIDTH + 1) : sgm_pkg::WIDTH_REG_BITS;
   localparam int HCMP_BITS = sgm_pkg::ROW_BITS + 1;
   localparam int HALF_BITS = sgm_pkg::ROOT_BITS - 1;
   localparam int SB        = sgm_pkg::SAMPLE_BITS;
   localparam int SUMB      = sgm_pkg::SUM_BITS;

   localparam logic [CMP_BITS-1:0]  MAX_W_C = CMP_BITS'(MAX_WIDTH);
   localparam logic [CMP_BITS-1:0]  MIN_W_C = CMP_BITS'(sgm_pkg::MIN_DIM);
   localparam logic [HCMP_BITS-1:0] MIN_H_C = HCMP_BITS'(sgm_pkg::MIN_DIM);
   localparam logic [HALF_BITS-1:0] SAT_C   = HALF_BITS'(sgm_pkg::SAMPLE_MAX);

   // control state
   sgm_pkg::state_type state_ff, state_in;

   // configuration registers
   logic [sgm_pkg::WIDTH_REG_BITS-1:0]  width_ff, width_in;
   logic [sgm_pkg::HEIGHT_REG_BITS-1:0] height_ff, height_in;

   // raster position
   logic [COL_BITS-1:0]           col_ff, col_in;
   logic [sgm_pkg::ROW_BITS-1:0]  row_ff, row_in;

   // item held while it works through the stages
   logic [SB-1:0]                     px_ff, px_in;
   logic [COL_BITS-1:0]               slot_ff, slot_in;
   logic                              emit_ff, emit_in;
   logic [sgm_pkg::OUT_COL_BITS-1:0]  ocol_ff, ocol_in;
   logic [sgm_pkg::ROW_BITS-1:0]      orow_ff, orow_in;

   // two previous columns of the window: 0..2 oldest, 3..5 newer, top to bottom
   logic [SB-1:0] window_ff [6];
   logic [SB-1:0] window_in [6];

   // arithmetic stages
   logic [sgm_pkg::ABS_BITS-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [sgm_pkg::SQ_BITS-1:0]  sqx_ff, sqx_in, sqy_ff, sqy_in;

   // output register
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0]                         rsp_grad_ff, rsp_grad_in;
   logic [sgm_pkg::OUT_COL_BITS-1:0]      rsp_col_ff, rsp_col_in;
   logic [sgm_pkg::ROW_BITS-1:0]          rsp_row_ff, rsp_row_in;

   // handshakes and stage controls
   logic accept;
   logic out_free;
   logic load_out;
   logic mem_rd_en;
   logic mem_wr_en;
   logic root_start;
   logic root_done;
   logic [sgm_pkg::ROOT_BITS-1:0]  root_val;
   logic [sgm_pkg::RAD_BITS-1:0]   radicand;
   logic [sgm_pkg::LINE_BITS-1:0]  mem_rd_data;
   logic [sgm_pkg::LINE_BITS-1:0]  mem_wr_data;

   // counter arithmetic
   logic [CMP_BITS-1:0]  width_ext, w_eff, col_ext, col_plus, col_minus;
   logic [HCMP_BITS-1:0] h_eff, row_plus;
   logic                 wrap_col, wrap_row;

   // kernel arithmetic
   logic [SB-1:0]          top_px, mid_px;
   logic signed [SUMB-1:0] tl, ml, bl, tm, bm, tr, mr, br;
   logic signed [SUMB-1:0] gx, gy;
   logic [SUMB-1:0]        gx_abs, gy_abs;
   logic [HALF_BITS-1:0]   half_root;

   //----------------------------------------------------------------------
   // line memory: word = {row before previous, previous row}
   //----------------------------------------------------------------------
   sgm_line_mem #(
      .DEPTH     (MAX_WIDTH),
      .ADDR_BITS (COL_BITS)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (col_ff),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (slot_ff),
      .wr_data (mem_wr_data)
   );

   assign top_px      = mem_rd_data[sgm_pkg::LINE_BITS-1 -: SB];
   assign mid_px      = mem_rd_data[SB-1:0];
   // shift the column down by one row on write-back
   assign mem_wr_data = {mid_px, px_ff};

   //----------------------------------------------------------------------
   // square root unit
   //----------------------------------------------------------------------
   assign radicand = sgm_pkg::RAD_BITS'(sqx_ff) + sgm_pkg::RAD_BITS'(sqy_ff);

   sgm_root u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (radicand),
      .done     (root_done),
      .root     (root_val)
   );

   //----------------------------------------------------------------------
   // handshake
   //----------------------------------------------------------------------
   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   //----------------------------------------------------------------------
   // next state
   //----------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sgm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sgm_pkg::ST_READ;
            end
         end
         sgm_pkg::ST_READ: begin
            state_in = emit_ff ? sgm_pkg::ST_SQUARE : sgm_pkg::ST_IDLE;
         end
         sgm_pkg::ST_SQUARE: begin
            state_in = sgm_pkg::ST_START;
         end
         sgm_pkg::ST_START: begin
            state_in = sgm_pkg::ST_ROOT;
         end
         sgm_pkg::ST_ROOT: begin
            if (root_done) begin
               state_in = out_free ? sgm_pkg::ST_IDLE : sgm_pkg::ST_HOLD;
            end
         end
         sgm_pkg::ST_HOLD: begin
            if (out_free) begin
               state_in = sgm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sgm_pkg::ST_IDLE;
         end
      endcase
   end

   //----------------------------------------------------------------------
   // state outputs
   //----------------------------------------------------------------------
   always_comb begin
      req_stall  = 1'b1;
      mem_rd_en  = 1'b0;
      mem_wr_en  = 1'b0;
      root_start = 1'b0;
      load_out   = 1'b0;
      case (state_ff)
         sgm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            mem_rd_en = req_valid;
         end
         sgm_pkg::ST_READ: begin
            mem_wr_en = 1'b1;
         end
         sgm_pkg::ST_SQUARE: begin
         end
         sgm_pkg::ST_START: begin
            root_start = 1'b1;
         end
         sgm_pkg::ST_ROOT: begin
            load_out = root_done && out_free;
         end
         sgm_pkg::ST_HOLD: begin
            load_out = out_free;
         end
         default: begin
         end
      endcase
   end

   //----------------------------------------------------------------------
   // raster counters, clamped frame size
   //----------------------------------------------------------------------
   always_comb begin
      width_ext = CMP_BITS'(width_ff);
      if (width_ext < MIN_W_C) begin
         w_eff = MIN_W_C;
      end else if (width_ext > MAX_W_C) begin
         w_eff = MAX_W_C;
      end else begin
         w_eff = width_ext;
      end
      h_eff = HCMP_BITS'(height_ff);
      if (h_eff < MIN_H_C) begin
         h_eff = MIN_H_C;
      end
   end

   assign col_ext   = CMP_BITS'(col_ff);
   assign col_plus  = col_ext + 1'b1;
   assign col_minus = col_ext - 1'b1;
   assign row_plus  = HCMP_BITS'(row_ff) + 1'b1;
   assign wrap_col  = col_plus >= w_eff;
   assign wrap_row  = row_plus >= h_eff;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      px_in   = px_ff;
      slot_in = slot_ff;
      emit_in = emit_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      if (accept) begin
         px_in   = req_pixel_value;
         slot_in = col_ff;
         emit_in = (col_ext >= CMP_BITS'(2)) && (row_ff >= sgm_pkg::ROW_BITS'(2));
         ocol_in = col_minus[sgm_pkg::OUT_COL_BITS-1:0];
         orow_in = row_ff - 1'b1;
         if (wrap_col) begin
            col_in = '0;
            row_in = wrap_row ? '0 : row_plus[sgm_pkg::ROW_BITS-1:0];
         end else begin
            col_in = col_plus[COL_BITS-1:0];
         end
      end
   end

   //----------------------------------------------------------------------
   // kernel stage: window plus the new column from memory and input
   //----------------------------------------------------------------------
   assign tl = signed'(SUMB'(window_ff[0]));
   assign ml = signed'(SUMB'(window_ff[1]));
   assign bl = signed'(SUMB'(window_ff[2]));
   assign tm = signed'(SUMB'(window_ff[3]));
   assign bm = signed'(SUMB'(window_ff[5]));
   assign tr = signed'(SUMB'(top_px));
   assign mr = signed'(SUMB'(mid_px));
   assign br = signed'(SUMB'(px_ff));

   assign gx     = (tr - tl) + ((mr - ml) <<< 1) + (br - bl);
   assign gy     = (bl + (bm <<< 1) + br) - (tl + (tm <<< 1) + tr);
   assign gx_abs = gx[SUMB-1] ? unsigned'(-gx) : unsigned'(gx);
   assign gy_abs = gy[SUMB-1] ? unsigned'(-gy) : unsigned'(gy);

   always_comb begin
      window_in = window_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      if (mem_wr_en) begin
         ax_in        = gx_abs[sgm_pkg::ABS_BITS-1:0];
         ay_in        = gy_abs[sgm_pkg::ABS_BITS-1:0];
         window_in[0] = window_ff[3];
         window_in[1] = window_ff[4];
         window_in[2] = window_ff[5];
         window_in[3] = top_px;
         window_in[4] = mid_px;
         window_in[5] = px_ff;
      end
   end

   // squares of both gradients
   assign sqx_in = ax_ff * ax_ff;
   assign sqy_in = ay_ff * ay_ff;

   //----------------------------------------------------------------------
   // output register: halve the root and saturate
   //----------------------------------------------------------------------
   assign half_root = root_val[sgm_pkg::ROOT_BITS-1:1];

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_grad_in  = rsp_grad_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_grad_in  = (half_root > SAT_C) ? sgm_pkg::SAMPLE_MAX : half_root[SB-1:0];
         rsp_col_in   = ocol_ff;
         rsp_row_in   = orow_ff;
      end
   end

   //----------------------------------------------------------------------
   // configuration writes
   //----------------------------------------------------------------------
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_en) begin
         case (csr_index)
            sgm_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_wdata[sgm_pkg::WIDTH_REG_BITS-1:0];
            end
            sgm_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = csr_wdata[sgm_pkg::HEIGHT_REG_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   //----------------------------------------------------------------------
   // registers
   //----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sgm_pkg::ST_IDLE;
         width_ff     <= sgm_pkg::WIDTH_REG_BITS'(160);
         height_ff    <= sgm_pkg::HEIGHT_REG_BITS'(120);
         col_ff       <= '0;
         row_ff       <= '0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
         window_ff    <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      slot_ff     <= slot_in;
      ocol_ff     <= ocol_in;
      orow_ff     <= orow_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      rsp_grad_ff <= rsp_grad_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_gradient = rsp_grad_ff;
   assign rsp_out_col  = rsp_col_ff;
   assign rsp_out_row  = rsp_row_ff;

`ifndef SYNTHESIS
   // every accepted pixel is followed by its memory write-back
   a_accept_then_read: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == sgm_pkg::ST_READ && mem_wr_en)
      else $error("accepted pixel not followed by line write-back");

   // memory write-back only right after an accepted pixel
   a_write_after_accept: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> $past(accept))
      else $error("line memory written without an accepted pixel");

   // the root unit finishes only while the control waits for it
   a_root_done_state: assert property (@(posedge clock) disable iff (reset)
      root_done |-> state_ff == sgm_pkg::ST_ROOT)
      else $error("square root finished outside root state");

   // a new result appears only from the root or hold state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == sgm_pkg::ST_ROOT ||
                                 state_ff == sgm_pkg::ST_HOLD))
      else $error("result raised without a finished computation");
`endif

endmodule

// File: tb/sv/sobel_gradient_magnitude_core_tb.sv
// self-checking testbench for the streaming sobel gradient magnitude core
`timescale 1ns / 1ps

// Pixels go in as random and hand-picked frames. A behavioral copy of the core
// runs alongside and predicts every gradient transaction. Results are checked
// in order, field by field, while both sides idle and stall at random.
module sobel_gradient_magnitude_core_tb;

   localparam int MAX_WIDTH     = 256;
   localparam int RANDOM_PIXELS = 600;
   // long enough for any work still in flight to finish
   localparam int SETTLE_CYCLES = 24;
   // give up on missing results after this many cycles of waiting
   localparam int DRAIN_LIMIT   = 50000;

   // one expected gradient transaction
   typedef struct packed {
      logic [sgm_pkg::SAMPLE_BITS-1:0]  gradient;
      logic [sgm_pkg::OUT_COL_BITS-1:0] col;
      logic [sgm_pkg::ROW_BITS-1:0]     row;
   } gradient_result_type;

   // dut inputs start known at time zero
   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [sgm_pkg::SAMPLE_BITS-1:0]    req_pixel_value = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [sgm_pkg::SAMPLE_BITS-1:0]    rsp_gradient;
   logic [sgm_pkg::OUT_COL_BITS-1:0]   rsp_out_col;
   logic [sgm_pkg::ROW_BITS-1:0]       rsp_out_row;
   logic                               csr_write_en = 1'b0;
   logic [sgm_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [sgm_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // predictor state: two stored rows, two window columns, raster position
   logic [sgm_pkg::SAMPLE_BITS-1:0]     older_row [MAX_WIDTH];
   logic [sgm_pkg::SAMPLE_BITS-1:0]     prev_row [MAX_WIDTH];
   logic [sgm_pkg::SAMPLE_BITS-1:0]     window_cols [6];
   int                                  col_pos;
   int                                  row_pos;
   logic [sgm_pkg::WIDTH_REG_BITS-1:0]  width_reg;
   logic [sgm_pkg::HEIGHT_REG_BITS-1:0] height_reg;

   // gradients predicted but not yet seen at the output
   gradient_result_type pending_gradients [$];

   // traffic shaping, percent of cycles spent idle on each side
   int sender_idle_pct;
   int receiver_idle_pct;
   int stall_hold_request;
   int stall_hold_left;

   int pixels_sent;
   int gradients_checked;
   int csr_writes;
   int error_count;

   sobel_gradient_magnitude_core #(
      .MAX_WIDTH(MAX_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pixel_value(req_pixel_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_gradient(rsp_gradient),
      .rsp_out_col(rsp_out_col),
      .rsp_out_row(rsp_out_row),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // register values outside the legal range are clamped by the core
   function automatic int active_width();
      if (width_reg < sgm_pkg::MIN_DIM) return sgm_pkg::MIN_DIM;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return int'(width_reg);
   endfunction

   function automatic int active_height();
      return (height_reg < sgm_pkg::MIN_DIM) ? sgm_pkg::MIN_DIM : int'(height_reg);
   endfunction

   // largest root whose square does not exceed the radicand, built msb first
   function automatic int unsigned floor_root(input int unsigned radicand);
      int unsigned root;
      int unsigned trial;
      root = 0;
      for (int b = 15; b >= 0; b--) begin
         trial = root | (32'd1 << b);
         if (trial * trial <= radicand) root = trial;
      end
      return root;
   endfunction

   // advance the model by one accepted pixel, queueing the gradient if any
   function automatic void predict_gradient(input logic [sgm_pkg::SAMPLE_BITS-1:0] px);
      int slot;
      int tl, ml, bl, tm, bm, top, mid, cur;
      int gx, gy, mag;
      gradient_result_type res;
      slot = col_pos;
      top  = older_row[slot];
      mid  = prev_row[slot];
      cur  = px;
      tl   = window_cols[0];
      ml   = window_cols[1];
      bl   = window_cols[2];
      tm   = window_cols[3];
      bm   = window_cols[5];

      // a full 3x3 window exists once both counters reach 2
      if (col_pos >= 2 && row_pos >= 2) begin
         gx  = (top - tl) + 2 * (mid - ml) + (cur - bl);
         gy  = (bl + 2 * bm + cur) - (tl + 2 * tm + top);
         mag = int'(floor_root(gx * gx + gy * gy) >> 1);
         res.gradient = (mag > int'(sgm_pkg::SAMPLE_MAX)) ? sgm_pkg::SAMPLE_MAX :
                        sgm_pkg::SAMPLE_BITS'(mag);
         res.col      = sgm_pkg::OUT_COL_BITS'(col_pos - 1);
         res.row      = sgm_pkg::ROW_BITS'(row_pos - 1);
         pending_gradients.push_back(res);
      end

      window_cols[0] = window_cols[3];
      window_cols[1] = window_cols[4];
      window_cols[2] = window_cols[5];
      window_cols[3] = sgm_pkg::SAMPLE_BITS'(top);
      window_cols[4] = sgm_pkg::SAMPLE_BITS'(mid);
      window_cols[5] = px;
      older_row[slot] = sgm_pkg::SAMPLE_BITS'(mid);
      prev_row[slot]  = px;

      // counters past a shrunk size wrap at their next advance
      if (col_pos + 1 >= active_width()) begin
         col_pos = 0;
         if (row_pos + 1 >= active_height()) row_pos = 0;
         else row_pos++;
      end else begin
         col_pos++;
      end
   endfunction

   // ------------------------------------------------------------------
   // output side: random stall plus an optional long hold-off
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (stall_hold_request > 0) begin
         stall_hold_left    = stall_hold_request;
         stall_hold_request = 0;
      end
      if (stall_hold_left > 0) begin
         stall_hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // compare every accepted result transaction with the oldest prediction
   always @(posedge clock) begin
      gradient_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_gradients.size() == 0) begin
            $error("unexpected gradient %0d at col %0d row %0d",
                   rsp_gradient, rsp_out_col, rsp_out_row);
            error_count++;
         end else begin
            want = pending_gradients.pop_front();
            if (rsp_gradient !== want.gradient) begin
               $error("gradient: expected %0d, got %0d", want.gradient, rsp_gradient);
               error_count++;
            end
            if (rsp_out_col !== want.col) begin
               $error("out_col: expected %0d, got %0d", want.col, rsp_out_col);
               error_count++;
            end
            if (rsp_out_row !== want.row) begin
               $error("out_row: expected %0d, got %0d", want.row, rsp_out_row);
               error_count++;
            end
            gradients_checked++;
         end
      end
   end

   // ------------------------------------------------------------------
   // shared stimulus tasks
   // ------------------------------------------------------------------

   // offer one pixel after a random gap and hold it until the transaction
   task automatic send_pixel(input logic [sgm_pkg::SAMPLE_BITS-1:0] px);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= px;
      do @(posedge clock); while (req_stall);
      predict_gradient(px);
      pixels_sent++;
   endtask

   // mostly uniform samples, with a bias toward the two extremes
   function automatic logic [sgm_pkg::SAMPLE_BITS-1:0] random_pixel();
      if ($urandom_range(3) == 0) return $urandom_range(1) ? sgm_pkg::SAMPLE_MAX : '0;
      return sgm_pkg::SAMPLE_BITS'($urandom_range(int'(sgm_pkg::SAMPLE_MAX)));
   endfunction

   task automatic send_random_pixels(input int count);
      repeat (count) send_pixel(random_pixel());
   endtask

   // one whole frame from the current position at the start of a frame
   task automatic send_frame();
      send_random_pixels(active_width() * active_height());
   endtask

   task automatic finish_frame();
      while (col_pos != 0 || row_pos != 0) send_pixel(random_pixel());
   endtask

   // drop valid, wait for every predicted gradient, then let the pipe settle
   task automatic wait_results_drained();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (pending_gradients.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_gradients.size() != 0) begin
         $error("%0d expected gradients never arrived", pending_gradients.size());
         error_count++;
         pending_gradients.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // only called while the core is idle
   task automatic write_csr(input logic [sgm_pkg::CSR_INDEX_BITS-1:0] reg_index,
                            input logic [sgm_pkg::CSR_DATA_BITS-1:0]  data);
      csr_write_en <= 1'b1;
      csr_index    <= reg_index;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      if (reg_index == sgm_pkg::CSR_IMAGE_WIDTH) begin
         width_reg = data[sgm_pkg::WIDTH_REG_BITS-1:0];
      end else begin
         height_reg = data[sgm_pkg::HEIGHT_REG_BITS-1:0];
      end
      csr_writes++;
   endtask

   // the width only grows at a frame start, so no unwritten line slot is read
   task automatic new_frame_size(input logic [sgm_pkg::CSR_DATA_BITS-1:0] width_data,
                                 input logic [sgm_pkg::CSR_DATA_BITS-1:0] height_data);
      wait_results_drained();
      if (col_pos != 0 || row_pos != 0) begin
         // shrinking is always safe and ends the frame within a few rows
         write_csr(sgm_pkg::CSR_IMAGE_WIDTH, sgm_pkg::CSR_DATA_BITS'(sgm_pkg::MIN_DIM));
         write_csr(sgm_pkg::CSR_IMAGE_HEIGHT, sgm_pkg::CSR_DATA_BITS'(sgm_pkg::MIN_DIM));
         finish_frame();
         wait_results_drained();
      end
      write_csr(sgm_pkg::CSR_IMAGE_WIDTH, width_data);
      write_csr(sgm_pkg::CSR_IMAGE_HEIGHT, height_data);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // sizes after reset, 160 wide: the third row gives the first interior pixels
   task automatic test_reset_sizes();
      sender_idle_pct   = 20;
      receiver_idle_pct = 30;
      send_random_pixels(2 * 160 + 8);
   endtask

   // hand-built windows: hard edges, corner, and the saturation boundary
   task automatic test_window_extremes();
      int corner_frame [12] = '{0, 0, 4095, 0, 0, 4095, 0, 0, 4095, 4095, 4095, 4095};
      // gx of 8188 halves to 4094, just under the clamp
      int below_clamp [9]   = '{0, 4094, 2047, 0, 1, 2047, 0, 4094, 2047};
      // gx of 8192 halves to 4096, clamped to 4095
      int at_clamp [9]      = '{0, 4095, 2048, 0, 0, 2048, 0, 4095, 2048};
      new_frame_size(sgm_pkg::CSR_DATA_BITS'(3), sgm_pkg::CSR_DATA_BITS'(4));
      foreach (corner_frame[i]) send_pixel(sgm_pkg::SAMPLE_BITS'(corner_frame[i]));
      new_frame_size(sgm_pkg::CSR_DATA_BITS'(3), sgm_pkg::CSR_DATA_BITS'(3));
      foreach (below_clamp[i]) send_pixel(sgm_pkg::SAMPLE_BITS'(below_clamp[i]));
      foreach (at_clamp[i]) send_pixel(sgm_pkg::SAMPLE_BITS'(at_clamp[i]));
   endtask

   // register values below the minimum, above the line length, and with
   // stray high bits on the width write
   task automatic test_size_limits();
      int width_data [6]  = '{0, 1, 2, 'hE05, 511, 3};
      int height_data [6] = '{0, 1, 2, 4, 3, 5};
      foreach (width_data[i]) begin
         new_frame_size(sgm_pkg::CSR_DATA_BITS'(width_data[i]),
                        sgm_pkg::CSR_DATA_BITS'(height_data[i]));
         send_frame();
      end
   endtask

   // narrowest frame with many rows, full rate on both sides
   task automatic test_tall_frame();
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      new_frame_size(sgm_pkg::CSR_DATA_BITS'(3), sgm_pkg::CSR_DATA_BITS'(64));
      send_frame();
   endtask

   // resize while the counters sit inside a frame
   task automatic test_midframe_resize();
      sender_idle_pct   = 25;
      receiver_idle_pct = 25;
      new_frame_size(sgm_pkg::CSR_DATA_BITS'(12), sgm_pkg::CSR_DATA_BITS'(10));
      // row 4 col 5: new height lies below the current row, wraps at row end
      send_random_pixels(4 * 12 + 5);
      wait_results_drained();
      write_csr(sgm_pkg::CSR_IMAGE_HEIGHT, sgm_pkg::CSR_DATA_BITS'(2));
      send_random_pixels(7);
      // row 2 col 7: width drops below the column, height grows again
      send_random_pixels(2 * 12 + 7);
      wait_results_drained();
      write_csr(sgm_pkg::CSR_IMAGE_WIDTH, sgm_pkg::CSR_DATA_BITS'(5));
      write_csr(sgm_pkg::CSR_IMAGE_HEIGHT, sgm_pkg::CSR_DATA_BITS'(9));
      finish_frame();
   endtask

   // long output hold-off with the input pushing, then an input pause
   task automatic test_backpressure();
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      new_frame_size(sgm_pkg::CSR_DATA_BITS'(10), sgm_pkg::CSR_DATA_BITS'(6));
      stall_hold_request = 400;
      send_frame();
      receiver_idle_pct = 50;
      send_random_pixels(25);
      // sender stops until every gradient so far has come out
      wait_results_drained();
      finish_frame();
   endtask

   // random frame with occasional mid-frame resize
   task automatic random_frame();
      int pick;
      int w;
      int h;
      pick = $urandom_range(19);
      if (pick == 0) begin
         w = $urandom_range(200, 256);
         h = 3;
      end else if (pick == 1) begin
         w = $urandom_range(1) ? $urandom_range(0, 2) : $urandom_range(257, 511);
         h = $urandom_range(0, 3);
      end else begin
         w = $urandom_range(3, 16);
         h = $urandom_range(3, 8);
      end
      // bits above the width register are don't-care
      new_frame_size(sgm_pkg::CSR_DATA_BITS'(w) |
                     (sgm_pkg::CSR_DATA_BITS'($urandom_range(7)) << sgm_pkg::WIDTH_REG_BITS),
                     sgm_pkg::CSR_DATA_BITS'(h));
      if ($urandom_range(3) == 0) begin
         send_random_pixels($urandom_range(1, active_width() * active_height() - 1));
         wait_results_drained();
         if ($urandom_range(1))
            write_csr(sgm_pkg::CSR_IMAGE_HEIGHT,
                      sgm_pkg::CSR_DATA_BITS'($urandom_range(0, 8)));
         else
            write_csr(sgm_pkg::CSR_IMAGE_WIDTH,
                      sgm_pkg::CSR_DATA_BITS'($urandom_range(0, active_width())));
         finish_frame();
      end else begin
         send_frame();
      end
   endtask

   // three traffic phases: slow output, slow input, full rate
   task automatic test_random_traffic();
      int sender_pcts [3]   = '{38, 81, 0};
      int receiver_pcts [3] = '{81, 38, 0};
      int phase_start;
      for (int p = 0; p < 3; p++) begin
         sender_idle_pct   = sender_pcts[p];
         receiver_idle_pct = receiver_pcts[p];
         phase_start       = pixels_sent;
         while (pixels_sent - phase_start < RANDOM_PIXELS / 3) random_frame();
      end
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------

   initial begin
      foreach (older_row[i]) older_row[i] = '0;
      foreach (prev_row[i]) prev_row[i] = '0;
      foreach (window_cols[i]) window_cols[i] = '0;
      col_pos            = 0;
      row_pos            = 0;
      width_reg          = sgm_pkg::WIDTH_REG_BITS'(160);
      height_reg         = sgm_pkg::HEIGHT_REG_BITS'(120);
      sender_idle_pct    = 0;
      receiver_idle_pct  = 0;
      stall_hold_request = 0;
      stall_hold_left    = 0;
      pixels_sent        = 0;
      gradients_checked  = 0;
      csr_writes         = 0;
      error_count        = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_sizes();
      test_window_extremes();
      test_size_limits();
      test_midframe_resize();
      test_backpressure();
      test_tall_frame();
      test_random_traffic();
      wait_results_drained();

      $display("%0d pixels sent, %0d gradients checked, %0d register writes",
               pixels_sent, gradients_checked, csr_writes);
      $display("frames 3 to 256 wide and up to 64 tall, resizes in and between frames");
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // watchdog, 20 ms is several times the slowest legal run
   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
